// File: src/bth_pkg.sv
package bth_pkg;

	localparam int HEAP_WORDS_DEF = 4096;
	localparam int CFG_W = 13;
	localparam int FUNC_W = 2;
	localparam int REQ_W = 15;
	localparam int STATUS_W = 2;
	localparam int PADDR_W = 14;
	localparam int WORD_W = 32;
	localparam logic [CFG_W-1:0] HEAP_WORDS_RST = 13'd4096;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_FORMAT = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_PTR = 2'd2;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd3;

	localparam int MIN_BLOCK = 8;

	// One request as the engine sees it.
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [REQ_W-1:0]  req_size;
		logic [REQ_W-1:0]  free_addr;
	} bth_req_t;

	// One finished response.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PADDR_W-1:0]  payload_addr;
	} bth_rsp_t;

endpackage

// File: src/bth_ram.sv
module bth_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/bth_engine.sv
module bth_engine #(
	parameter int HEAP_WORDS = bth_pkg::HEAP_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  bth_pkg::bth_req_t             req,
	input  logic [bth_pkg::CFG_W-1:0]     heap_words,
	output logic                          busy,
	output logic                          done,
	output bth_pkg::bth_rsp_t             rsp
);

	localparam int AW = $clog2(HEAP_WORDS);
	// Byte offsets, with one bit of headroom for off + size.
	localparam int BW = AW + 3;

	typedef enum logic [4:0] {
		S_IDLE, S_W_RD, S_W_CHK, S_A_HDR, S_A_SPLIT2, S_A_SPLIT3, S_A_NXT_RD,
		S_A_NXT_WR, S_F_HDR_RD, S_F_HDR_CHK, S_F_FOOT, S_F_NXT_RD, S_F_NXT_WR,
		S_F_PREV_RD, S_F_PREV_CHK, S_F_START_RD, S_F_START_CHK, S_F_FIN1,
		S_F_FIN2, S_FMT2, S_DONE
	} state_t;

	typedef logic [bth_pkg::PADDR_W-1:0] paddr_t;

	state_t state_q;
	logic [BW-1:0] total_q, off_q, blk_q, best_off_q, best_size_q;
	logic [BW-1:0] start_q, size_q, fsz_q;
	logic          found_q, headbit_q, ready_q, hbit_q;
	logic [AW:0]   active_q;
	logic [bth_pkg::STATUS_W-1:0] st_q;
	logic [bth_pkg::PADDR_W-1:0]  addr_q;

	logic                  we;
	logic [AW-1:0]         waddr, raddr;
	logic [31:0]           wdata, rdata;
	logic [AW-1:0]         raddr_q;

	bth_ram #(.WIDTH(bth_pkg::WORD_W), .DEPTH(HEAP_WORDS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	function automatic logic [AW-1:0] widx(input logic [BW-1:0] b);
		return b[AW+1:2];
	endfunction

	// Header fields of the word just read.
	logic [BW-1:0] rsz;
	logic [BW:0]   rend;
	logic [BW-1:0] fmt_hw;
	logic [BW-1:0] req_blk;
	logic [bth_pkg::REQ_W+3:0] blk_full;
	assign rsz = (rdata[31:BW] != '0) ? {BW{1'b1}} & ~BW'(3) : {rdata[BW-1:2], 2'b00};
	assign rend = {1'b0, off_q} + {1'b0, rsz};

	always_comb begin
		fmt_hw = BW'(heap_words);
		if (heap_words < 13'd2) fmt_hw = BW'(2);
		if (32'(heap_words) > HEAP_WORDS) fmt_hw = BW'(HEAP_WORDS);
		blk_full = {({2'b00, req.req_size} + 17'd7) >> 2, 2'b00};
		// A block too large for the offset width saturates; it can never fit.
		if (req.req_size <= 15'd4)
			req_blk = BW'(bth_pkg::MIN_BLOCK);
		else if (32'(blk_full) > 32'({BW{1'b1}} & ~BW'(3)))
			req_blk = {BW{1'b1}} & ~BW'(3);
		else
			req_blk = BW'(blk_full);
	end

	// Memory port control.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = raddr_q;
		case (state_q)
			S_IDLE: begin
				if (start && req.func == bth_pkg::FUNC_FORMAT) begin
					we = 1'b1;
					waddr = '0;
					wdata = 32'({fmt_hw, 2'b10});
				end
			end
			S_FMT2: begin
				we = 1'b1;
				waddr = widx(total_q - BW'(4));
				wdata = 32'(total_q);
			end
			S_A_HDR: begin
				we = 1'b1;
				waddr = widx(best_off_q);
				if (best_size_q - blk_q >= BW'(bth_pkg::MIN_BLOCK))
					wdata = 32'(blk_q) | {30'd0, rdata[1], 1'b1};
				else
					wdata = 32'(best_size_q) | {30'd0, rdata[1], 1'b1};
			end
			S_A_SPLIT2: begin
				we = 1'b1;
				waddr = widx(best_off_q + blk_q);
				wdata = 32'(best_size_q - blk_q) | 32'd2;
			end
			S_A_SPLIT3: begin
				// Only a split writes the remainder's footer; an unsplit take
				// merely reads the next header here.
				we = !hbit_q;
				waddr = widx(best_off_q + best_size_q - BW'(4));
				wdata = 32'(best_size_q - blk_q);
			end
			S_A_NXT_WR: begin
				we = 1'b1;
				waddr = raddr_q;
				wdata = rdata | 32'd2;
			end
			S_F_HDR_CHK: begin
				we = rdata[0] && rsz >= BW'(bth_pkg::MIN_BLOCK) && rend <= {1'b0, total_q};
				waddr = raddr_q;
				wdata = 32'(rsz) | {30'd0, rdata[1], 1'b0};
			end
			S_F_FOOT: begin
				we = 1'b1;
				waddr = widx(off_q + fsz_q - BW'(4));
				wdata = 32'(fsz_q);
			end
			S_F_NXT_WR: begin
				we = 1'b1;
				waddr = raddr_q;
				wdata = rdata & ~32'd2;
			end
			S_F_FIN1: begin
				we = 1'b1;
				waddr = widx(start_q);
				wdata = 32'(size_q) | {30'd0, headbit_q, 1'b0};
			end
			S_F_FIN2: begin
				we = 1'b1;
				waddr = widx(start_q + size_q - BW'(4));
				wdata = 32'(size_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			active_q <= '0;
			st_q <= bth_pkg::ST_OK;
			addr_q <= '0;
			found_q <= 1'b0;
			raddr_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					total_q <= BW'({active_q, 2'b00});
					found_q <= 1'b0;
					addr_q <= '0;
					off_q <= '0;
					blk_q <= req_blk;
					if (start) begin
						state_q <= S_DONE;
						if (req.func == bth_pkg::FUNC_FORMAT) begin
							active_q <= (AW+1)'(fmt_hw);
							total_q <= BW'({fmt_hw, 2'b00});
							ready_q <= 1'b1;
							st_q <= bth_pkg::ST_OK;
							state_q <= S_FMT2;
						end else if (req.func != bth_pkg::FUNC_ALLOC &&
								req.func != bth_pkg::FUNC_FREE) begin
							st_q <= bth_pkg::ST_BAD_SIZE;
						end else if (!ready_q) begin
							st_q <= bth_pkg::ST_NOT_READY;
						end else if (req.func == bth_pkg::FUNC_ALLOC) begin
							if (req.req_size == '0) begin
								st_q <= bth_pkg::ST_BAD_SIZE;
							end else begin
								raddr_q <= '0;
								state_q <= S_W_RD;
							end
						end else begin
							if (req.free_addr < 15'd4 || req.free_addr[1:0] != 2'b00 ||
									17'(req.free_addr) >= 17'({active_q, 2'b00})) begin
								st_q <= bth_pkg::ST_BAD_PTR;
							end else begin
								off_q <= BW'(req.free_addr) - BW'(4);
								raddr_q <= widx(BW'(req.free_addr) - BW'(4));
								state_q <= S_F_HDR_RD;
							end
						end
					end
				end
				S_FMT2: state_q <= S_DONE;
				S_W_RD: state_q <= S_W_CHK;
				S_W_CHK: begin
					if (rsz == '0 || rend > {1'b0, total_q}) begin
						state_q <= found_q ? S_A_NXT_RD : S_DONE;
						st_q <= found_q ? bth_pkg::ST_OK : bth_pkg::ST_BAD_SIZE;
						raddr_q <= widx(best_off_q);
					end else if (!rdata[0] && rsz == blk_q) begin
						best_off_q <= off_q;
						best_size_q <= rsz;
						found_q <= 1'b1;
						st_q <= bth_pkg::ST_OK;
						raddr_q <= widx(off_q);
						state_q <= S_A_NXT_RD;
					end else begin
						if (!rdata[0] && rsz > blk_q && (!found_q || rsz < best_size_q)) begin
							best_off_q <= off_q;
							best_size_q <= rsz;
							found_q <= 1'b1;
						end
						off_q <= rend[BW-1:0];
						raddr_q <= widx(rend[BW-1:0]);
						if (rend[BW-1:0] >= total_q) begin
							state_q <= S_A_NXT_RD;
							raddr_q <= (!rdata[0] && rsz > blk_q && (!found_q ||
								rsz < best_size_q)) ? widx(off_q) : widx(best_off_q);
							st_q <= (found_q || (!rdata[0] && rsz > blk_q))
								? bth_pkg::ST_OK : bth_pkg::ST_BAD_SIZE;
							if (!(found_q || (!rdata[0] && rsz > blk_q)))
								state_q <= S_DONE;
						end else begin
							state_q <= S_W_RD;
						end
					end
				end
				// Header of the chosen block is being read.
				S_A_NXT_RD: state_q <= S_A_HDR;
				S_A_HDR: begin
					addr_q <= paddr_t'(best_off_q + BW'(4));
					if (best_size_q - blk_q >= BW'(bth_pkg::MIN_BLOCK)) begin
						state_q <= S_A_SPLIT2;
					end else if (best_off_q + best_size_q < total_q) begin
						raddr_q <= widx(best_off_q + best_size_q);
						state_q <= S_A_SPLIT3;
						hbit_q <= 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_A_SPLIT2: begin
					hbit_q <= 1'b0;
					state_q <= S_A_SPLIT3;
				end
				S_A_SPLIT3: state_q <= hbit_q ? S_A_NXT_WR : S_DONE;
				S_A_NXT_WR: state_q <= S_DONE;
				S_F_HDR_RD: state_q <= S_F_HDR_CHK;
				S_F_HDR_CHK: begin
					fsz_q <= rsz;
					start_q <= off_q;
					size_q <= rsz;
					headbit_q <= rdata[1];
					hbit_q <= rdata[1];
					if (!rdata[0] || rsz < BW'(bth_pkg::MIN_BLOCK) || rend > {1'b0, total_q}) begin
						st_q <= bth_pkg::ST_BAD_PTR;
						state_q <= S_DONE;
					end else begin
						st_q <= bth_pkg::ST_OK;
						state_q <= S_F_FOOT;
					end
				end
				S_F_FOOT: begin
					raddr_q <= widx(off_q + fsz_q);
					if (off_q + fsz_q < total_q) state_q <= S_F_NXT_RD;
					else state_q <= S_F_PREV_RD;
					if (!(off_q + fsz_q < total_q)) raddr_q <= widx(off_q - BW'(4));
				end
				S_F_NXT_RD: state_q <= S_F_NXT_WR;
				S_F_NXT_WR: begin
					if (!rdata[0] && rsz != '0 &&
							{1'b0, off_q} + {1'b0, fsz_q} + {1'b0, rsz} <= {1'b0, total_q})
						size_q <= size_q + rsz;
					raddr_q <= widx(off_q - BW'(4));
					state_q <= S_F_PREV_RD;
				end
				S_F_PREV_RD: begin
					if (!hbit_q && off_q >= BW'(bth_pkg::MIN_BLOCK)) state_q <= S_F_PREV_CHK;
					else state_q <= S_F_FIN1;
				end
				S_F_PREV_CHK: begin
					if (rsz >= BW'(bth_pkg::MIN_BLOCK) && rsz <= off_q) begin
						start_q <= off_q - rsz;
						size_q <= size_q + rsz;
						raddr_q <= widx(off_q - rsz);
						state_q <= S_F_START_RD;
					end else begin
						state_q <= S_F_FIN1;
					end
				end
				S_F_START_RD: state_q <= S_F_START_CHK;
				S_F_START_CHK: begin
					headbit_q <= rdata[1];
					state_q <= S_F_FIN1;
				end
				S_F_FIN1: state_q <= S_F_FIN2;
				S_F_FIN2: state_q <= S_DONE;
				S_DONE: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp.status = st_q;
	assign rsp.payload_addr = (st_q == bth_pkg::ST_OK) ? addr_q : '0;

	ap_done_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q != S_IDLE) || $past(start)) else $error("done without work");
	ap_walk_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_W_CHK |-> off_q < total_q) else $error("walk past heap end");
	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE |=> state_q == S_IDLE) else $error("done not followed by idle");

endmodule

// File: src/boundary_tag_heap_allocator.sv
// Boundary-tag heap allocator, best fit over an implicit block list.
// Requests arrive on the in channel (in_valid/in_ready) with func, req_size
// and free_addr; one response beat per request leaves on the out channel
// (out_valid/out_ready) with status and payload_addr.
// heap_words is written through cfg_we/cfg_data and takes effect at the
// next format request.
// A request turned away at intake goes straight to the response; a format
// writes the heap header and then its footer, and a free checks the header
// and merges with any free neighbour. An allocate walks the block headers
// through the registered heap memory read port until an exact fit or the
// heap end, then writes the chosen block.
// One request is worked on at a time. The next one is accepted no earlier
// than the cycle in which out_valid rises, and only while the output
// register is empty or drains in that cycle, so a stalled receiver holds
// in_ready low until it takes the waiting beat.
// Reset clears the formatted flag and restores heap_words to 4096; the
// heap memory itself is not cleared, a format lays it out.
module boundary_tag_heap_allocator #(
	parameter int HEAP_WORDS = bth_pkg::HEAP_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bth_pkg::FUNC_W-1:0]       func,
	input  logic [bth_pkg::REQ_W-1:0]        req_size,
	input  logic [bth_pkg::REQ_W-1:0]        free_addr,
	input  logic                             cfg_we,
	input  logic [bth_pkg::CFG_W-1:0]        cfg_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bth_pkg::STATUS_W-1:0]     status,
	output logic [bth_pkg::PADDR_W-1:0]      payload_addr
);

	logic [bth_pkg::CFG_W-1:0] heap_words_q;
	bth_pkg::bth_req_t req;
	bth_pkg::bth_rsp_t rsp, rsp_q;
	logic busy, done, start, out_valid_q;

	// A new request may start when the engine is idle and the output
	// register is free or is being drained this cycle.
	assign in_ready = !busy && (!out_valid_q || out_ready);
	assign start = in_valid && in_ready;
	assign req.func = func;
	assign req.req_size = req_size;
	assign req.free_addr = free_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_words_q <= bth_pkg::HEAP_WORDS_RST;
		end else if (cfg_we) begin
			heap_words_q <= cfg_data;
		end
	end

	bth_engine #(.HEAP_WORDS(HEAP_WORDS)) u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.heap_words(heap_words_q), .busy(busy), .done(done), .rsp(rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) rsp_q <= rsp;
	end

	assign out_valid = out_valid_q;
	assign status = rsp_q.status;
	assign payload_addr = rsp_q.payload_addr;

	ap_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q || out_ready) else $error("response overwritten");
	ap_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy) else $error("start while busy");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("response dropped");

endmodule

// File: test/boundary_tag_heap_allocator_test.sv
module boundary_tag_heap_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int HW = bth_pkg::HEAP_WORDS_DEF;
	// The one func code that names no operation.
	localparam logic [bth_pkg::FUNC_W-1:0] FUNC_UNDEF = 2'd3;

	// Scoreboard: a private copy of the heap, the format settings and the queue
	// of responses that are still owed by the block.
	class heap_scoreboard;
		logic [31:0] words [HW];
		int unsigned live_words;
		bit formatted;
		int unsigned size_reg;
		logic [bth_pkg::STATUS_W-1:0] exp_status [$];
		logic [bth_pkg::PADDR_W-1:0] exp_addr [$];
		int unsigned errors;
		int unsigned live_allocs [$];

		function new();
			live_words = 0;
			formatted = 0;
			size_reg = 4096;
			errors = 0;
		endfunction

		function logic [31:0] rd(longint unsigned b);
			longint unsigned w;
			w = b / 4;
			return (w < HW) ? words[w] : 32'd0;
		endfunction

		function void wr(longint unsigned b, logic [31:0] v);
			longint unsigned w;
			w = b / 4;
			if (w < HW)
				words[w] = v;
		endfunction

		function int alloc_block(int unsigned req, output int unsigned addr);
			longint unsigned total, blk, off, best_off, best_sz, sz, rem, nxt;
			logic [31:0] h, pb;
			bit found;
			total = 64'(live_words) * 4;
			off = 0;
			best_off = 0;
			best_sz = 0;
			found = 0;
			addr = 0;
			if (req == 0)
				return bth_pkg::ST_BAD_SIZE;
			blk = (req <= 4) ? 64'd8 : 4 * ((64'(req) + 7) / 4);
			while (off < total) begin
				h = rd(off);
				sz = 64'(h & ~32'd3);
				if (sz == 0 || off + sz > total)
					break;
				if (h[0] == 1'b0) begin
					if (sz == blk) begin
						best_off = off;
						best_sz = sz;
						found = 1;
						break;
					end
					if (sz > blk && (!found || sz < best_sz)) begin
						best_off = off;
						best_sz = sz;
						found = 1;
					end
				end
				off += sz;
			end
			if (!found)
				return bth_pkg::ST_BAD_SIZE;
			pb = rd(best_off) & 32'd2;
			rem = best_sz - blk;
			if (rem >= 8) begin
				wr(best_off, 32'(blk) | pb | 32'd1);
				wr(best_off + blk, 32'(rem) | 32'd2);
				wr(best_off + best_sz - 4, 32'(rem));
			end else begin
				nxt = best_off + best_sz;
				wr(best_off, 32'(best_sz) | pb | 32'd1);
				if (nxt < total)
					wr(nxt, rd(nxt) | 32'd2);
			end
			addr = 32'(best_off + 4);
			return bth_pkg::ST_OK;
		endfunction

		function int free_block(int unsigned a);
			longint unsigned total, off, sz, nxt, start, size, nsz, psz;
			logic [31:0] h, nh, hb;
			total = 64'(live_words) * 4;
			if (a < 4 || (a & 3) != 0 || 64'(a) >= total)
				return bth_pkg::ST_BAD_PTR;
			off = 64'(a) - 4;
			h = rd(off);
			sz = 64'(h & ~32'd3);
			if (h[0] == 1'b0 || sz < 8 || off + sz > total)
				return bth_pkg::ST_BAD_PTR;
			wr(off, 32'(sz) | (h & 32'd2));
			wr(off + sz - 4, 32'(sz));
			nxt = off + sz;
			start = off;
			size = sz;
			hb = h & 32'd2;
			if (nxt < total) begin
				nh = rd(nxt) & ~32'd2;
				nsz = 64'(nh & ~32'd3);
				wr(nxt, nh);
				if (nh[0] == 1'b0 && nsz != 0 && nxt + nsz <= total)
					size += nsz;
			end
			if (h[1] == 1'b0 && off >= 8) begin
				psz = 64'(rd(off - 4) & ~32'd3);
				if (psz >= 8 && psz <= off) begin
					start = off - psz;
					size += psz;
					hb = rd(start) & 32'd2;
				end
			end
			wr(start, 32'(size) | hb);
			wr(start + size - 4, 32'(size));
			return bth_pkg::ST_OK;
		endfunction

		// Note one accepted request beat and queue the response it must cause.
		function void note_request(logic [bth_pkg::FUNC_W-1:0] f, int unsigned req,
				int unsigned fa);
			int st;
			int unsigned addr, hw;
			addr = 0;
			if (f == bth_pkg::FUNC_FORMAT) begin
				hw = size_reg;
				if (hw < 2)
					hw = 2;
				if (hw > HW)
					hw = HW;
				live_words = hw;
				formatted = 1;
				wr(0, (hw * 4) | 32'd2);
				wr(64'(hw - 1) * 4, hw * 4);
				st = bth_pkg::ST_OK;
				live_allocs.delete();
			end else if (f == FUNC_UNDEF) begin
				st = bth_pkg::ST_BAD_SIZE;
			end else if (!formatted) begin
				st = bth_pkg::ST_NOT_READY;
			end else if (f == bth_pkg::FUNC_ALLOC) begin
				st = alloc_block(req, addr);
				if (st == bth_pkg::ST_OK)
					live_allocs.push_back(addr);
			end else begin
				st = free_block(fa);
			end
			if (st != bth_pkg::ST_OK)
				addr = 0;
			exp_status.push_back(st[bth_pkg::STATUS_W-1:0]);
			exp_addr.push_back(addr[bth_pkg::PADDR_W-1:0]);
		endfunction

		// Compare one response beat against the oldest owed response.
		function void check_response(logic [bth_pkg::STATUS_W-1:0] st,
				logic [bth_pkg::PADDR_W-1:0] pa);
			logic [bth_pkg::STATUS_W-1:0] es;
			logic [bth_pkg::PADDR_W-1:0] ea;
			if (exp_status.size() == 0) begin
				$display("%0t: unexpected response status %0d addr %0d", $time, st, pa);
				errors++;
				return;
			end
			es = exp_status.pop_front();
			ea = exp_addr.pop_front();
			if (st !== es) begin
				$display("%0t: status expected %0d actual %0d", $time, es, st);
				errors++;
			end
			if (pa !== ea) begin
				$display("%0t: payload_addr expected %0d actual %0d", $time, ea, pa);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [bth_pkg::FUNC_W-1:0] func = '0;
	logic [bth_pkg::REQ_W-1:0] req_size = '0;
	logic [bth_pkg::REQ_W-1:0] free_addr = '0;
	logic cfg_we = 1'b0;
	logic [bth_pkg::CFG_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [bth_pkg::STATUS_W-1:0] status;
	logic [bth_pkg::PADDR_W-1:0] payload_addr;

	// When set, neither side inserts idle cycles any more.
	bit steady = 0;
	heap_scoreboard board;

	always #5 clk = ~clk;

	boundary_tag_heap_allocator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.func(func),
		.req_size(req_size),
		.free_addr(free_addr),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.payload_addr(payload_addr)
	);

	// Response side: sample at the rising edge, move ready at the falling edge.
	// Stalls come in random bursts.
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				board.check_response(status, payload_addr);
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				out_ready <= 1'b0;
			end else if (!steady && $urandom_range(0, 9) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Present one request beat and hold it until the block takes it. Valid
	// stays high across back-to-back beats unless a random idle burst comes first.
	task automatic send_request(logic [bth_pkg::FUNC_W-1:0] f, int unsigned req,
			int unsigned fa);
		int gap;
		if (!steady && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
		end
		func <= f;
		req_size <= req[bth_pkg::REQ_W-1:0];
		free_addr <= fa[bth_pkg::REQ_W-1:0];
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(f, req & 32'h7fff, fa & 32'h7fff);
		@(negedge clk);
	endtask

	// Drop valid and wait until every owed response has come back.
	task automatic drain();
		in_valid <= 1'b0;
		while (board.exp_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// The register is only written while the block is idle.
	task automatic set_heap_words(int unsigned hw);
		drain();
		cfg_data <= hw[bth_pkg::CFG_W-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.size_reg = hw & 32'h1fff;
	endtask

	// A mostly well-formed mix: allocations of small sizes, frees of live
	// pointers, and some noise such as bad pointers, zero and huge sizes.
	task automatic random_request();
		int unsigned r, idx, sz, fa;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			sz = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32767)
				: $urandom_range(1, 64);
			send_request(bth_pkg::FUNC_ALLOC, sz, $urandom());
		end else if (r < 85 && board.live_allocs.size() != 0) begin
			idx = $urandom_range(0, board.live_allocs.size() - 1);
			fa = board.live_allocs[idx];
			board.live_allocs.delete(idx);
			send_request(bth_pkg::FUNC_FREE, $urandom(), fa);
		end else if (r < 95) begin
			// Stray pointers that are turned away before any heap word is read:
			// below the first payload, misaligned, or past the heap end.
			case ($urandom_range(0, 2))
				0: fa = $urandom_range(0, 3);
				1: fa = ($urandom_range(1, 8191) << 2) | $urandom_range(1, 3);
				default: fa = $urandom_range(board.live_words * 4, 32767);
			endcase
			send_request(bth_pkg::FUNC_FREE, $urandom(), fa);
		end else if (r < 98) begin
			send_request(FUNC_UNDEF, $urandom(), $urandom());
		end else begin
			send_request(bth_pkg::FUNC_FORMAT, $urandom(), $urandom());
		end
	endtask

	initial begin
		int unsigned settings [5];
		int unsigned p;
		board = new();
		settings = '{64, 2, 200, 4096, 8191};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part: requests before any format, the smallest heap, exact
		// fits, splits, double and misaligned frees.
		send_request(bth_pkg::FUNC_ALLOC, 4, 0);
		send_request(bth_pkg::FUNC_FREE, 0, 4);
		send_request(FUNC_UNDEF, 32767, 32767);
		set_heap_words(0);
		send_request(bth_pkg::FUNC_FORMAT, 0, 0);
		send_request(bth_pkg::FUNC_ALLOC, 1, 0);
		send_request(bth_pkg::FUNC_ALLOC, 0, 0);
		set_heap_words(16);
		send_request(bth_pkg::FUNC_FORMAT, 0, 0);
		send_request(bth_pkg::FUNC_ALLOC, 4, 0);
		send_request(bth_pkg::FUNC_ALLOC, 5, 0);
		send_request(bth_pkg::FUNC_ALLOC, 32, 0);
		send_request(bth_pkg::FUNC_ALLOC, 12, 0);
		send_request(bth_pkg::FUNC_FREE, 0, 4);
		send_request(bth_pkg::FUNC_FREE, 0, 4);
		send_request(bth_pkg::FUNC_FREE, 0, 6);
		send_request(bth_pkg::FUNC_FREE, 0, 0);
		send_request(bth_pkg::FUNC_FREE, 0, 64);
		// Pointer into the small free block at the heap end.
		send_request(bth_pkg::FUNC_FREE, 0, 60);
		send_request(bth_pkg::FUNC_FREE, 0, 32767);
		send_request(bth_pkg::FUNC_ALLOC, 4, 0);
		send_request(bth_pkg::FUNC_ALLOC, 16384, 0);
		send_request(bth_pkg::FUNC_ALLOC, 32767, 0);
		drain();

		// Random part in phases across several heap sizes. The register
		// extremes (the minimum, and a value above the parameter that is clamped) are included.
		for (p = 0; p < 5; p++) begin
			set_heap_words(settings[p]);
			send_request(bth_pkg::FUNC_FORMAT, 0, 0);
			if (p == 4)
				steady = 1;
			repeat (230) begin
				random_request();
				if ($urandom_range(0, 199) == 0)
					drain();
			end
		end

		drain();
		repeat (50) @(negedge clk);
		if (board.errors == 0 && board.exp_status.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin
		#500ms;
		$display("Verification failed");
		$finish;
	end
endmodule
